FILE: sv/pics_pkg.sv
// Package with types, widths and constants of the PI controller with integral separation.
`timescale 1ns / 1ps

package pics_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DUTY_W     = 17;
    localparam int GAIN_W     = 24;
    localparam int SEP_W      = 31;
    localparam int VAL_W      = 32;
    localparam int ERR_W      = VAL_W + 1;
    localparam int PROD_W     = GAIN_W + 1 + ERR_W;
    localparam int SHR_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W      = SHR_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_THRESHOLD = 3'd4;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 24'd32768;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST    = 24'd655;
    localparam logic [DUTY_W-1:0] OUT_LOW_RST       = 17'd0;
    localparam logic [DUTY_W-1:0] OUT_HIGH_RST      = 17'd62259;
    localparam logic [SEP_W-1:0]  SEP_THRESHOLD_RST = 31'd32768;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_RESET  = 1'b1;

    typedef struct packed {
        logic                    command;
        logic signed [VAL_W-1:0] target;
        logic signed [VAL_W-1:0] measured;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              integrating;
        logic              clamped;
    } t_out_item;

    typedef struct packed {
        logic [DUTY_W-1:0] value;
        logic              hit;
    } t_limit;

    // Clamps to the upper bound first and then to the lower bound.
    function automatic t_limit f_limit(
        input logic signed [SUM_W-1:0] v,
        input logic [DUTY_W-1:0]       lo,
        input logic [DUTY_W-1:0]       hi
    );
        logic signed [SUM_W-1:0] lo_s;
        logic signed [SUM_W-1:0] hi_s;
        logic signed [SUM_W-1:0] t;
        t_limit                  res;
        lo_s = $signed({{(SUM_W-DUTY_W){1'b0}}, lo});
        hi_s = $signed({{(SUM_W-DUTY_W){1'b0}}, hi});
        t = v;
        res.hit = 1'b0;
        if (t > hi_s) begin
            t = hi_s;
            res.hit = 1'b1;
        end
        if (t < lo_s) begin
            t = lo_s;
            res.hit = 1'b1;
        end
        res.value = t[DUTY_W-1:0];
        return res;
    endfunction

endpackage

FILE: sv/pi_controller_integral_separation_unit.sv
// Top level of the PI controller with integral separation and anti-windup.
`timescale 1ns / 1ps

// The controller takes one transaction per clock cycle unless o_stall is high, and
// returns one result per transaction from the result register. An input register
// feeds a single pass that forms the error, both gain products, the integral update
// and the clamped duty, and the result register holds the answer; the integral
// state is updated as a transaction leaves the input register, so consecutive
// transactions see each other's integral without a gap. Configuration registers are
// written through a plain write port and must only change while the block is idle.
module pi_controller_integral_separation_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  pics_pkg::t_in_item              i_item,
    output logic                            o_valid,
    input  logic                            i_stall,
    output pics_pkg::t_out_item             o_result,
    input  logic                            i_cfg_we,
    input  logic [pics_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pics_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pics_pkg::*;

    logic [GAIN_W-1:0] r_prop_gain;
    logic [GAIN_W-1:0] r_integ_gain;
    logic [DUTY_W-1:0] r_out_low;
    logic [DUTY_W-1:0] r_out_high;
    logic [SEP_W-1:0]  r_sep_threshold;
    logic [DUTY_W-1:0] r_integ_acc;
    logic [DUTY_W-1:0] n_integ_acc;

    logic      r_a_valid;
    t_in_item  r_a_item;
    logic      r_b_valid;
    t_out_item r_b_result;
    t_out_item n_b_result;

    logic b_free;
    logic a_move;
    logic in_accept;

    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         mag;
    logic                     integ_upd;
    logic signed [PROD_W-1:0] iprod;
    logic signed [PROD_W-1:0] pprod;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [SUM_W-1:0]  out_sum;
    t_limit                   acc_lim;
    t_limit                   out_lim;

    assign b_free    = !r_b_valid || !i_stall;
    assign a_move    = r_a_valid && b_free;
    assign o_stall   = r_a_valid && !b_free;
    assign in_accept = i_valid && !o_stall;

    assign o_valid  = r_b_valid;
    assign o_result = r_b_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= PROP_GAIN_RST;
            r_integ_gain    <= INTEG_GAIN_RST;
            r_out_low       <= OUT_LOW_RST;
            r_out_high      <= OUT_HIGH_RST;
            r_sep_threshold <= SEP_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:    r_integ_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_OUT_LOW:       r_out_low       <= i_cfg_data[DUTY_W-1:0];
                CFG_OUT_HIGH:      r_out_high      <= i_cfg_data[DUTY_W-1:0];
                CFG_SEP_THRESHOLD: r_sep_threshold <= i_cfg_data[SEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        err = $signed({r_a_item.target[VAL_W-1], r_a_item.target})
            - $signed({r_a_item.measured[VAL_W-1], r_a_item.measured});
        mag = err[ERR_W-1] ? ERR_W'(-err) : err;
        integ_upd = mag < {{(ERR_W-SEP_W){1'b0}}, r_sep_threshold};

        iprod = $signed({1'b0, r_integ_gain}) * err;
        pprod = $signed({1'b0, r_prop_gain}) * err;

        acc_sum = $signed({{(SUM_W-SHR_W){iprod[PROD_W-1]}}, iprod[PROD_W-1:FRAC_BITS]})
                + $signed({{(SUM_W-DUTY_W){1'b0}}, r_integ_acc});
        acc_lim = f_limit(acc_sum, r_out_low, r_out_high);

        n_integ_acc = r_integ_acc;
        if (r_a_item.command == CMD_RESET) begin
            n_integ_acc = '0;
        end else if (integ_upd) begin
            n_integ_acc = acc_lim.value;
        end

        out_sum = $signed({{(SUM_W-SHR_W){pprod[PROD_W-1]}}, pprod[PROD_W-1:FRAC_BITS]})
                + $signed({{(SUM_W-DUTY_W){1'b0}}, n_integ_acc});
        out_lim = f_limit(out_sum, r_out_low, r_out_high);

        if (r_a_item.command == CMD_RESET) begin
            n_b_result = '0;
        end else begin
            n_b_result.duty        = out_lim.value;
            n_b_result.integrating = integ_upd;
            n_b_result.clamped     = out_lim.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_integ_acc <= '0;
        end else begin
            if (in_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_b_valid   <= 1'b1;
                r_integ_acc <= n_integ_acc;
            end else if (b_free) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_item <= i_item;
        end
        if (a_move) begin
            r_b_result <= n_b_result;
        end
    end

    a_reset_clears_integral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && r_a_item.command == CMD_RESET) |=> (r_integ_acc == '0))
        else $error("Integral not cleared by a reset command.");

    a_reset_answers_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && r_a_item.command == CMD_RESET) |=> (o_valid && o_result == '0))
        else $error("Reset command did not answer duty zero.");

    a_frozen_integral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_move && r_a_item.command == CMD_UPDATE && !integ_upd)
            |=> (r_integ_acc == $past(r_integ_acc)))
        else $error("Integral changed outside the separation band.");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && r_b_valid))
        else $error("Input stalled while the pipeline has room.");

endmodule
